[rtl/hrsl_pkg.sv]
`default_nettype none

package hrsl_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int NODE_BITS_DEF  = 16;

  localparam int POINT_W  = 32;
  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // flipping the sign bit makes unsigned compare follow signed order
  localparam logic [POINT_W-1:0] SIGN_FLIP = 32'h8000_0000;

  // fan-in of one level of the result tree
  localparam int TREE_FAN  = 16;
  localparam int TREE_LOG  = 4;
  localparam int TREE_MAXL = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // strobes and key broadcast to every cell
  typedef struct packed {
    logic               insert;
    logic               clear;
    logic               lookup;
    logic [POINT_W-1:0] key;
  } hrsl_cmd_t;

  // flags a cell hands to its upper neighbor
  typedef struct packed {
    logic valid;
    logic after;
    logic gt;
  } hrsl_link_t;

  // nodes at tree level l (level 0 are the leaves)
  function automatic int tree_cnt(input int n, input int l);
    return (n + (1 << (TREE_LOG * l)) - 1) >> (TREE_LOG * l);
  endfunction

  function automatic int tree_levels(input int n);
    int lv;
    lv = 0;
    for (int l = TREE_MAXL; l >= 1; l--) begin
      if (tree_cnt(n, l) == 1) begin
        lv = l;
      end
    end
    return lv;
  endfunction

  // offset of level l (l >= 1) in the flat tree storage
  function automatic int tree_off(input int n, input int l);
    int off;
    off = 0;
    for (int k = 1; k <= TREE_MAXL; k++) begin
      if (k < l) begin
        off += tree_cnt(n, k);
      end
    end
    return off;
  endfunction

endpackage

`default_nettype wire

[rtl/hrsl_if.sv]
`default_nettype none

interface hrsl_req_if;
  import hrsl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [POINT_W-1:0] point;
  logic [ID_W-1:0]           node_id;

  modport source (output valid, output kind, output point, output node_id, input ready);
  modport sink   (input valid, input kind, input point, input node_id, output ready);
endinterface

interface hrsl_rsp_if;
  import hrsl_pkg::*;
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     node_id_out;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output node_id_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input node_id_out, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

[rtl/hrsl_cell.sv]
`default_nettype none

module hrsl_cell
  import hrsl_pkg::*;
#(
  parameter int NODE_BITS = NODE_BITS_DEF,
  parameter bit FIRST     = 1'b0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hrsl_cmd_t            cmd,
  input  wire logic [NODE_BITS-1:0] node_in,
  input  wire hrsl_link_t           prev_link,
  input  wire logic [POINT_W-1:0]   prev_point,
  input  wire logic [NODE_BITS-1:0] prev_node,
  output hrsl_link_t                link,
  output logic [POINT_W-1:0]        point,
  output logic [NODE_BITS-1:0]      node,
  output logic [NODE_BITS:0]        hit
);

  logic                 valid_r;
  logic [POINT_W-1:0]   point_r;
  logic [NODE_BITS-1:0] node_r;
  logic [NODE_BITS:0]   hit_r;
  logic                 above;
  logic                 shift_in;
  logic                 first_gt;

  assign above    = point_r > cmd.key;
  assign shift_in = !FIRST && prev_link.after;
  assign first_gt = valid_r && above && !(!FIRST && prev_link.gt);

  assign link.valid = valid_r;
  assign link.after = !valid_r || above;
  assign link.gt    = valid_r && above;
  assign point      = point_r;
  assign node       = node_r;
  assign hit        = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.clear) begin
      valid_r <= 1'b0;
    end else if (cmd.insert) begin
      valid_r <= FIRST ? 1'b1 : prev_link.valid;
    end
  end

  // entries at and above the insert spot move up by one
  always_ff @(posedge clk) begin
    if (cmd.insert && link.after) begin
      point_r <= shift_in ? prev_point : cmd.key;
      node_r  <= shift_in ? prev_node : node_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r <= first_gt ? {1'b1, node_r} : '0;
    end
  end

endmodule

`default_nettype wire

[rtl/hrsl_or_tree.sv]
`default_nettype none

module hrsl_or_tree
  import hrsl_pkg::*;
#(
  parameter int LEAVES = RING_DEPTH_DEF,
  parameter int W      = NODE_BITS_DEF + 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] leaves [LEAVES],
  output logic [W-1:0]      root
);

  localparam int LEVELS = tree_levels(LEAVES);
  localparam int TOTAL  = tree_off(LEAVES, LEVELS + 1);

  logic [W-1:0] tree_r [TOTAL];

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int IN_CNT  = tree_cnt(LEAVES, l - 1);
    localparam int OUT_CNT = tree_cnt(LEAVES, l);
    localparam int OFF     = tree_off(LEAVES, l);
    localparam int SRC_OFF = (l > 1) ? tree_off(LEAVES, l - 1) : 0;
    for (genvar j = 0; j < OUT_CNT; j++) begin : g_node
      logic [W-1:0] part [TREE_FAN];
      logic [W-1:0] acc;
      for (genvar k = 0; k < TREE_FAN; k++) begin : g_in
        if (j * TREE_FAN + k >= IN_CNT) begin : g_pad
          assign part[k] = '0;
        end else if (l == 1) begin : g_leaf
          assign part[k] = leaves[j * TREE_FAN + k];
        end else begin : g_inner
          assign part[k] = tree_r[SRC_OFF + j * TREE_FAN + k];
        end
      end
      always_comb begin
        acc = '0;
        for (int k = 0; k < TREE_FAN; k++) begin
          acc = acc | part[k];
        end
      end
      always_ff @(posedge clk) begin
        tree_r[OFF + j] <= acc;
      end
    end
  end

  assign root = tree_r[TOTAL - 1];

endmodule

`default_nettype wire

[rtl/hash_ring_successor_lookup.sv]
// result path: the cells register their hits, which then pass the LEVELS levels of the
//   16-way registered OR tree over the cells (2 at 256 entries, 3 up to 4096)
// handshake: a new request is taken while idle or at the edge that takes the result, so only
//   one request is in flight; an insert shifts the whole cell row at the edge that accepts it
// reset: entry count, cell valid bits and handshake state clear synchronously; stored points and
//   node indices are undefined until written
`default_nettype none

module hash_ring_successor_lookup
  import hrsl_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int NODE_BITS  = NODE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hrsl_req_if.sink    in_req,
  hrsl_rsp_if.source  out_rsp
);

  localparam int LEVELS = tree_levels(RING_DEPTH);
  localparam int CW     = $clog2(RING_DEPTH + 1);
  localparam int SW     = $clog2(LEVELS + 1);

  logic                 busy_r;
  logic [SW-1:0]        stage_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [STATUS_W-1:0]  status_r;
  logic [STATUS_W-1:0]  status_nxt;
  logic [CW-1:0]        rsp_count_r;
  logic                 lookup_r;
  logic                 eq0_r;
  logic [NODE_BITS-1:0] node0_r;

  logic                 in_acc;
  logic                 out_acc;
  logic                 full;
  hrsl_cmd_t            cmd;
  logic [NODE_BITS-1:0] node_in;
  logic [NODE_BITS:0]   root;
  logic [NODE_BITS-1:0] found;

  hrsl_link_t           link  [RING_DEPTH];
  logic [POINT_W-1:0]   cpoint[RING_DEPTH];
  logic [NODE_BITS-1:0] cnode [RING_DEPTH];
  logic [NODE_BITS:0]   hit   [RING_DEPTH];

  assign out_rsp.valid = busy_r && (stage_r == '0);
  assign out_acc       = out_rsp.valid && out_rsp.ready;
  assign in_req.ready  = !busy_r || out_acc;
  assign in_acc        = in_req.valid && in_req.ready;

  assign full    = count_r == CW'(RING_DEPTH);
  assign node_in = NODE_BITS'(in_req.node_id);

  always_comb begin
    cmd        = '0;
    cmd.key    = in_req.point ^ SIGN_FLIP;
    count_nxt  = count_r;
    status_nxt = STATUS_OK;
    case (in_req.kind)
      KIND_INSERT: begin
        if (full) begin
          status_nxt = STATUS_FULL;
        end else begin
          cmd.insert = in_acc;
          count_nxt  = count_r + 1'b1;
        end
      end
      KIND_LOOKUP: begin
        cmd.lookup = in_acc;
        if (count_r == '0) begin
          status_nxt = STATUS_EMPTY;
        end
      end
      KIND_CLEAR: begin
        cmd.clear = in_acc;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    localparam int P = (i == 0) ? 0 : i - 1;
    hrsl_cell #(
      .NODE_BITS (NODE_BITS),
      .FIRST     (i == 0)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .node_in    (node_in),
      .prev_link  (link[P]),
      .prev_point (cpoint[P]),
      .prev_node  (cnode[P]),
      .link       (link[i]),
      .point      (cpoint[i]),
      .node       (cnode[i]),
      .hit        (hit[i])
    );
  end

  hrsl_or_tree #(
    .LEAVES (RING_DEPTH),
    .W      (NODE_BITS + 1)
  ) u_tree (
    .clk    (clk),
    .leaves (hit),
    .root   (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      stage_r <= '0;
      count_r <= '0;
    end else if (in_acc) begin
      busy_r  <= 1'b1;
      stage_r <= SW'(LEVELS);
      count_r <= count_nxt;
    end else if (out_acc) begin
      busy_r <= 1'b0;
    end else if (stage_r != '0) begin
      stage_r <= stage_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r    <= status_nxt;
      rsp_count_r <= count_nxt;
      lookup_r    <= (in_req.kind == KIND_LOOKUP) && (count_r != '0);
      eq0_r       <= cpoint[0] == cmd.key;
      node0_r     <= cnode[0];
    end
  end

  // a query equal to the first point, or past every point, wraps to the first entry
  assign found = (eq0_r || !root[NODE_BITS]) ? node0_r : root[NODE_BITS-1:0];

  assign out_rsp.node_id_out = lookup_r ? ID_W'(found) : '0;
  assign out_rsp.status      = status_r;
  assign out_rsp.entry_count = COUNT_W'(rsp_count_r);

endmodule

`default_nettype wire

[rtl/hrsl_checker.sv]
`default_nettype none

module hrsl_checker
  import hrsl_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic [KIND_W-1:0]   in_kind,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [ID_W-1:0]     node_id_out,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [COUNT_W-1:0]  entry_count
);

  logic              pend_r;
  logic [KIND_W-1:0] kind_r;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (in_acc) begin
      pend_r <= 1'b1;
    end else if (out_acc) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(node_id_out) && $stable(status) &&
      $stable(entry_count))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r)
    else $error("result without a pending request");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind_r == KIND_CLEAR |->
      entry_count == '0 && status == STATUS_OK && node_id_out == '0)
    else $error("clear did not empty the ring");

  a_error_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STATUS_OK |-> node_id_out == '0)
    else $error("error result carries a node index");

  a_empty_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STATUS_EMPTY |-> entry_count == '0 && kind_r == KIND_LOOKUP)
    else $error("empty status on a non-empty ring or non-lookup");

endmodule

bind hash_ring_successor_lookup hrsl_checker u_hrsl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .in_kind     (in_req.kind),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .node_id_out (out_rsp.node_id_out),
  .status      (out_rsp.status),
  .entry_count (out_rsp.entry_count)
);

`default_nettype wire
